// ===== src/gate_envelope_generator_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef GATE_ENVELOPE_GENERATOR_TOP_MACROS_SVH
`define GATE_ENVELOPE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define GATE_ENV_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gate envelope check failed: same-cycle rule");

// Next-cycle implication, masked while reset is high.
`define GATE_ENV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gate envelope check failed: next-cycle rule");

// Same-cycle implication that is checked through reset as well.
`define GATE_ENV_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("gate envelope check failed: reset rule");

`endif

// ===== src/gate_env_pkg.sv =====
package gate_env_pkg;

   localparam int LEVEL_W     = 18;
   localparam int GAIN_W      = 17;
   localparam int ATTACK_W    = 17;
   localparam int HOLD_W      = 24;
   localparam int PHASE_W     = 25;
   localparam int FRAC_W      = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;

   localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'h10000;
   localparam logic [GAIN_W-1:0]  MIN_AUDIBLE = 17'd6;
   localparam logic [PHASE_W-1:0] PHASE_ONE   = 25'h1000000;
   localparam logic [HOLD_W-1:0]  HOLD_MAX    = 24'hFFFFFF;
   localparam logic [PHASE_W:0]   HARD_ROUND  = 26'd128;

   typedef enum logic [1:0] {
      MODE_CLOSED,
      MODE_ATTACK,
      MODE_HOLD,
      MODE_RELEASE
   } gate_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD,
      CSR_ATTACK_STEP,
      CSR_HOLD_SAMPLES,
      CSR_RELEASE_STEP,
      CSR_SOFT_SHAPE
   } csr_index_type;

   // Two neighboring curve points and the interpolation fraction.
   typedef struct packed {
      logic [GAIN_W-1:0] upper;
      logic [GAIN_W-1:0] lower;
      logic [FRAC_W-1:0] frac;
   } curve_tap_type;

endpackage

// ===== src/gate_env_req_if.sv =====
interface gate_env_req_if;
   import gate_env_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] trigger_level;

   modport source (output valid, output trigger_level, input ready);
   modport sink   (input valid, input trigger_level, output ready);
endinterface

// ===== src/gate_env_rsp_if.sv =====
interface gate_env_rsp_if;
   import gate_env_pkg::*;

   logic              valid;
   logic              ready;
   logic [GAIN_W-1:0] gain_out;
   logic              gate_open;

   modport source (output valid, output gain_out, output gate_open, input ready);
   modport sink   (input valid, input gain_out, input gate_open, output ready);
endinterface

// ===== src/gate_envelope_generator_top.sv =====
// Noise gate envelope generator: closed / attack / hold / release.
//
// req_word carries one trigger level per audio sample; rsp_word returns the
// gain and gate-open flag for that sample. Both are valid/ready channels and
// a word moves on a rising edge with valid and ready high.
// Latency: the result word is valid the cycle after its request is taken.
// Throughput: one word per cycle while rsp_ready is high. The envelope registers are the
// result register; the soft curve ROM is read with registered data one
// sample ahead, addressed by the precomputed next release phase.
// When rsp_ready is low and a result waits, req_ready drops and the result
// holds; a new request is taken in the same cycle the waiting result leaves.
// Reset (synchronous, active high) closes the gate with zero gain, restores
// register defaults and empties the result stage; req_ready is low during
// reset and a word can be taken in the first cycle after it.
// csr_* writes one setting per cycle; write only while no word is in flight.
module gate_envelope_generator_top #(
   parameter int CURVE_ENTRIES = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gate_env_req_if.sink                         req_word,
   gate_env_rsp_if.source                       rsp_word,
   input  logic                                 csr_write_enable,
   input  logic [gate_env_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gate_env_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import gate_env_pkg::*;

   // settings
   logic [LEVEL_W-1:0]  threshold_ff;
   logic [ATTACK_W-1:0] attack_step_ff;
   logic [HOLD_W-1:0]   hold_samples_ff;
   logic [PHASE_W-1:0]  release_step_ff;
   logic                soft_shape_ff;

   // envelope state
   gate_mode_type       mode_ff, mode_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [HOLD_W-1:0]   hold_count_ff, hold_count_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   // phase the next release sample would use: min(phase + step, 1.0)
   logic [PHASE_W-1:0]  cand_ff, cand_in;
   logic                out_valid_ff, out_valid_in;

   logic                accept;
   logic                trig;
   logic [GAIN_W:0]     attack_sum;
   logic                attack_done;
   logic [HOLD_W-1:0]   hold_next;
   logic                hold_expired;
   logic [PHASE_W:0]    hard_sum;
   logic [GAIN_W-1:0]   hard_gain;
   logic [GAIN_W-1:0]   tap_diff;
   logic [GAIN_W+FRAC_W-1:0] tap_prod;
   logic [GAIN_W-1:0]   soft_gain;
   logic [GAIN_W-1:0]   release_gain;
   logic                release_quiet;
   logic [PHASE_W-1:0]  cand_base;
   logic [PHASE_W-1:0]  cand_step;
   logic [PHASE_W:0]    cand_sum;
   curve_tap_type       tap;

   assign req_word.ready   = !reset && (!out_valid_ff || rsp_word.ready);
   assign accept           = req_word.valid && req_word.ready;
   assign rsp_word.valid     = out_valid_ff;
   assign rsp_word.gain_out  = gain_ff;
   assign rsp_word.gate_open = (mode_ff != MODE_CLOSED);

   // ---- per-sample decisions ----
   assign trig        = (req_word.trigger_level >= threshold_ff);
   assign attack_sum  = {1'b0, gain_ff} + {1'b0, attack_step_ff};
   assign attack_done = (attack_sum >= {1'b0, GAIN_ONE});

   always_comb begin
      if (trig) begin
         hold_next = '0;
      end else if (hold_count_ff < HOLD_MAX) begin
         hold_next = hold_count_ff + 1'b1;
      end else begin
         hold_next = hold_count_ff;
      end
   end
   assign hold_expired = (hold_next >= hold_samples_ff);

   // hard curve: (1 - t) rounded to Q1.16
   assign hard_sum  = {1'b0, PHASE_ONE} - {1'b0, cand_ff} + HARD_ROUND;
   assign hard_gain = hard_sum[PHASE_W-1:8];

   // soft curve: linear interpolation between the two prefetched points
   assign tap_diff     = tap.upper - tap.lower;
   assign tap_prod     = (GAIN_W+FRAC_W)'(tap_diff) * (GAIN_W+FRAC_W)'(tap.frac);
   assign soft_gain    = tap.upper - tap_prod[GAIN_W+FRAC_W-1:FRAC_W];
   assign release_gain = soft_shape_ff ? soft_gain : hard_gain;
   assign release_quiet = (release_gain <= MIN_AUDIBLE);

   // ---- next mode ----
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         case (mode_ff)
            MODE_CLOSED: begin
               if (trig) mode_in = MODE_ATTACK;
            end
            MODE_ATTACK: begin
               if (attack_done) mode_in = MODE_HOLD;
            end
            MODE_HOLD: begin
               if (hold_expired) mode_in = MODE_RELEASE;
            end
            MODE_RELEASE: begin
               if (trig) begin
                  mode_in = MODE_ATTACK;
               end else if (release_quiet) begin
                  mode_in = MODE_CLOSED;
               end
            end
            default: mode_in = MODE_CLOSED;
         endcase
      end
   end

   // ---- gain, hold count and phase ----
   always_comb begin
      gain_in       = gain_ff;
      hold_count_in = hold_count_ff;
      phase_in      = phase_ff;
      if (accept) begin
         case (mode_ff)
            MODE_CLOSED: begin
               gain_in = gain_ff;
            end
            MODE_ATTACK: begin
               if (attack_done) begin
                  gain_in       = GAIN_ONE;
                  hold_count_in = '0;
               end else begin
                  gain_in = attack_sum[GAIN_W-1:0];
               end
            end
            MODE_HOLD: begin
               gain_in       = GAIN_ONE;
               hold_count_in = hold_next;
               if (hold_expired) phase_in = '0;
            end
            MODE_RELEASE: begin
               // retrigger keeps the gain and resumes attack from it
               if (!trig) begin
                  phase_in = cand_ff;
                  gain_in  = release_quiet ? '0 : release_gain;
               end
            end
            default: gain_in = gain_ff;
         endcase
      end
   end

   // next candidate phase follows the phase and any new release step
   assign cand_base = phase_in;
   assign cand_step = (csr_write_enable && csr_index == CSR_RELEASE_STEP)
                      ? csr_write_data[PHASE_W-1:0] : release_step_ff;
   assign cand_sum  = {1'b0, cand_base} + {1'b0, cand_step};
   always_comb begin
      if (reset) begin
         cand_in = PHASE_ONE;
      end else if (cand_sum > {1'b0, PHASE_ONE}) begin
         cand_in = PHASE_ONE;
      end else begin
         cand_in = cand_sum[PHASE_W-1:0];
      end
   end

   always_comb begin
      if (accept) begin
         out_valid_in = 1'b1;
      end else if (rsp_word.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CLOSED;
         gain_ff       <= '0;
         hold_count_ff <= '0;
         phase_ff      <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         gain_ff       <= gain_in;
         hold_count_ff <= hold_count_in;
         phase_ff      <= phase_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

   // settings port; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= '0;
         attack_step_ff  <= GAIN_ONE;
         hold_samples_ff <= '0;
         release_step_ff <= PHASE_ONE;
         soft_shape_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_THRESHOLD:    threshold_ff    <= csr_write_data[LEVEL_W-1:0];
            CSR_ATTACK_STEP:  attack_step_ff  <= csr_write_data[ATTACK_W-1:0];
            CSR_HOLD_SAMPLES: hold_samples_ff <= csr_write_data[HOLD_W-1:0];
            CSR_RELEASE_STEP: release_step_ff <= csr_write_data[PHASE_W-1:0];
            CSR_SOFT_SHAPE:   soft_shape_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   gate_env_curve_rom #(
      .CURVE_ENTRIES(CURVE_ENTRIES)
   ) u_curve_rom (
      .clock (clock),
      .phase (cand_in),
      .tap   (tap)
   );
endmodule

// ===== src/gate_env_curve_rom.sv =====
module gate_env_curve_rom #(
   parameter int CURVE_ENTRIES = 1024
) (
   input  logic                               clock,
   input  logic [gate_env_pkg::PHASE_W-1:0]   phase,
   output gate_env_pkg::curve_tap_type        tap
);
   import gate_env_pkg::*;

   localparam int AW = $clog2(CURVE_ENTRIES + 1);
   localparam int PW = FRAC_W + AW;

   typedef logic [GAIN_W-1:0] curve_rom_type [CURVE_ENTRIES+1];

   // (1-t)^2.2 as u^2 * u^(1/5), fifth root found by bisection on truncated powers.
   function automatic curve_rom_type build_curve();
      curve_rom_type   tbl;
      longint unsigned u;
      longint unsigned sq;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned p;
      for (int k = 0; k <= CURVE_ENTRIES; k++) begin
         u  = (64'(CURVE_ENTRIES - k) << 16) / CURVE_ENTRIES;
         lo = 0;
         hi = 65536;
         for (int i = 0; i < 18; i++) begin
            if (lo < hi) begin
               mid = lo + ((hi - lo + 1) >> 1);
               p   = mid;
               for (int j = 0; j < 4; j++) begin
                  p = (p * mid) >> 16;
               end
               if (p <= u) begin
                  lo = mid;
               end else begin
                  hi = mid - 1;
               end
            end
         end
         sq     = (u * u) >> 16;
         tbl[k] = GAIN_W'((sq * lo) >> 16);
      end
      return tbl;
   endfunction

   localparam curve_rom_type CURVE_ROM = build_curve();

   logic [PW-1:0]     pos;
   logic [AW-1:0]     idx;
   logic [AW-1:0]     idx_next;
   logic [GAIN_W-1:0] upper_ff;
   logic [GAIN_W-1:0] lower_ff;
   logic [FRAC_W-1:0] frac_ff;

   assign pos      = PW'(phase) * PW'(CURVE_ENTRIES);
   assign idx      = pos[PW-1:FRAC_W];
   // last point has no neighbor; the fraction is zero there anyway
   assign idx_next = (idx >= AW'(CURVE_ENTRIES)) ? AW'(CURVE_ENTRIES) : idx + 1'b1;

   always_ff @(posedge clock) begin
      upper_ff <= CURVE_ROM[idx];
      lower_ff <= CURVE_ROM[idx_next];
      frac_ff  <= pos[FRAC_W-1:0];
   end

   assign tap = '{upper: upper_ff, lower: lower_ff, frac: frac_ff};
endmodule

// ===== src/gate_env_checker.sv =====
`include "gate_envelope_generator_top_macros.svh"

module gate_env_assertions (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [gate_env_pkg::GAIN_W-1:0] rsp_gain_out,
   input logic                            rsp_gate_open
);
   // result word holds while stalled
   `GATE_ENV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_gain_out) && $stable(rsp_gate_open))

   // every taken request produces a result in the next cycle
   `GATE_ENV_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready, rsp_valid)

   // a closed gate never passes signal
   `GATE_ENV_ASSERT_IMPL(a_closed_silent, clock, reset, rsp_valid && !rsp_gate_open, rsp_gain_out == '0)

   // result stage is empty right after reset
   `GATE_ENV_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset), !rsp_valid)
endmodule

bind gate_envelope_generator_top gate_env_assertions u_assertions (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_word.valid),
   .req_ready     (req_word.ready),
   .rsp_valid     (rsp_word.valid),
   .rsp_ready     (rsp_word.ready),
   .rsp_gain_out  (rsp_word.gain_out),
   .rsp_gate_open (rsp_word.gate_open)
);
